>>> rtl/rbbc_pkg.sv
// ----------------------------------------------------------------------------
// rbbc_pkg
// shared widths, constants and stage records for the bottom-center block
// ----------------------------------------------------------------------------
`default_nettype none

package rbbc_pkg;

    localparam int COORD_BITS      = 24;
    localparam int TRIG_FRAC_BITS  = 14;
    localparam int COORD_FRAC_BITS = 8;
    localparam int TRIG_BITS       = TRIG_FRAC_BITS + 2;
    localparam int SENTINEL_MM     = 10000;

    // shifted z is one bit wider than a coordinate
    localparam int ZS_BITS   = COORD_BITS + 1;
    localparam int PROD_X    = COORD_BITS + TRIG_BITS;
    localparam int PROD_Z    = ZS_BITS + TRIG_BITS;
    localparam int SUM_BITS  = PROD_Z + 1;
    localparam int CFG_BITS  = (COORD_BITS > TRIG_BITS) ? COORD_BITS : TRIG_BITS;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_COS    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SIN    = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_ZSHIFT = CFG_IDX_BITS'(2);

    localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) <<< (COORD_BITS - 1));
    localparam longint SENT_FULL = longint'(SENTINEL_MM) <<< COORD_FRAC_BITS;
    localparam longint SENT_VAL  = (SENT_FULL > COORD_MAX) ? COORD_MAX : SENT_FULL;

    localparam logic signed [COORD_BITS-1:0] SENT_HI = COORD_BITS'(SENT_VAL);
    localparam logic signed [COORD_BITS-1:0] SENT_LO = COORD_BITS'(-SENT_VAL);

    localparam logic signed [SUM_BITS-1:0] SAT_HI   = SUM_BITS'(COORD_MAX);
    localparam logic signed [SUM_BITS-1:0] SAT_LO   = SUM_BITS'(COORD_MIN);
    localparam logic signed [SUM_BITS-1:0] ROUND_HF = SUM_BITS'(longint'(1) <<< (TRIG_FRAC_BITS - 1));

    localparam logic signed [TRIG_BITS-1:0]  COS_RESET = TRIG_BITS'(longint'(1) <<< TRIG_FRAC_BITS);
    localparam logic signed [TRIG_BITS-1:0]  SIN_RESET = '0;
    localparam logic signed [COORD_BITS-1:0] ZSH_RESET = '0;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // captured vertex, z already shifted
    typedef struct packed {
        logic                      valid;
        logic                      last;
        t_coord                    x;
        t_coord                    y;
        logic signed [ZS_BITS-1:0] zs;
    } t_vtx;

    // rotated vertex
    typedef struct packed {
        logic   valid;
        logic   last;
        t_coord rx;
        t_coord y;
        t_coord rz;
    } t_rot;

    // finished extremes of one mesh
    typedef struct packed {
        logic   valid;
        t_coord low_x;
        t_coord high_x;
        t_coord low_y;
        t_coord high_y;
        t_coord low_z;
    } t_ext;

    // round half up, drop fraction, clamp to the coordinate range
    function automatic t_coord round_sat(input logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS-1:0] r;
        r = (v + ROUND_HF) >>> TRIG_FRAC_BITS;
        if (r > SAT_HI) begin
            return COORD_BITS'(SAT_HI);
        end else if (r < SAT_LO) begin
            return COORD_BITS'(SAT_LO);
        end
        return r[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/rbbc_rotate.sv
// ----------------------------------------------------------------------------
// rbbc_rotate
// two-stage xz rotation: registered products, then sum, round and clamp
// ----------------------------------------------------------------------------
`default_nettype none

module rbbc_rotate
    import rbbc_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire t_vtx                        i_vtx,
    input  wire logic signed [TRIG_BITS-1:0] i_cos,
    input  wire logic signed [TRIG_BITS-1:0] i_sin,
    output t_rot                             o_rot
);

    logic                       r_p_valid;
    logic                       r_p_last;
    t_coord                     r_p_y;
    logic signed [PROD_X-1:0]   r_xc;
    logic signed [PROD_X-1:0]   r_xs;
    logic signed [PROD_Z-1:0]   r_zc;
    logic signed [PROD_Z-1:0]   r_zs;
    t_rot                       r_rot;

    logic signed [SUM_BITS-1:0] n_sum_x;
    logic signed [SUM_BITS-1:0] n_sum_z;

    always_comb begin
        n_sum_x = SUM_BITS'(r_xc) - SUM_BITS'(r_zs);
        n_sum_z = SUM_BITS'(r_xs) + SUM_BITS'(r_zc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_rot.valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid   <= i_vtx.valid;
            r_rot.valid <= r_p_valid;
        end
        if (i_en) begin
            r_p_last   <= i_vtx.last;
            r_p_y      <= i_vtx.y;
            r_xc       <= i_vtx.x * i_cos;
            r_xs       <= i_vtx.x * i_sin;
            r_zc       <= i_vtx.zs * i_cos;
            r_zs       <= i_vtx.zs * i_sin;
            r_rot.last <= r_p_last;
            r_rot.y    <= r_p_y;
            r_rot.rx   <= round_sat(n_sum_x);
            r_rot.rz   <= round_sat(n_sum_z);
        end
    end

    assign o_rot = r_rot;

endmodule

`default_nettype wire

>>> rtl/rbbc_extents.sv
// ----------------------------------------------------------------------------
// rbbc_extents
// running extremes of the rotated cloud, handed off on the last vertex
// ----------------------------------------------------------------------------
`default_nettype none

module rbbc_extents
    import rbbc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire t_rot i_rot,
    input  wire logic i_take,
    output t_ext      o_done
);

    t_coord r_low_x, r_high_x, r_low_y, r_high_y, r_low_z;
    t_coord n_low_x, n_high_x, n_low_y, n_high_y, n_low_z;
    t_ext   r_done;

    // strict compares against the current extreme
    always_comb begin
        n_low_x  = (i_rot.rx < r_low_x)  ? i_rot.rx : r_low_x;
        n_high_x = (i_rot.rx > r_high_x) ? i_rot.rx : r_high_x;
        n_low_y  = (i_rot.y  < r_low_y)  ? i_rot.y  : r_low_y;
        n_high_y = (i_rot.y  > r_high_y) ? i_rot.y  : r_high_y;
        n_low_z  = (i_rot.rz < r_low_z)  ? i_rot.rz : r_low_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_x      <= SENT_HI;
            r_high_x     <= SENT_LO;
            r_low_y      <= SENT_HI;
            r_high_y     <= SENT_LO;
            r_low_z      <= SENT_HI;
            r_done.valid <= 1'b0;
        end else begin
            if (i_en && i_rot.valid) begin
                if (i_rot.last) begin
                    r_low_x  <= SENT_HI;
                    r_high_x <= SENT_LO;
                    r_low_y  <= SENT_HI;
                    r_high_y <= SENT_LO;
                    r_low_z  <= SENT_HI;
                end else begin
                    r_low_x  <= n_low_x;
                    r_high_x <= n_high_x;
                    r_low_y  <= n_low_y;
                    r_high_y <= n_high_y;
                    r_low_z  <= n_low_z;
                end
            end
            if (i_en && i_rot.valid && i_rot.last) begin
                r_done.valid <= 1'b1;
            end else if (i_take) begin
                r_done.valid <= 1'b0;
            end
        end
        if (i_en && i_rot.valid && i_rot.last) begin
            r_done.low_x  <= n_low_x;
            r_done.high_x <= n_high_x;
            r_done.low_y  <= n_low_y;
            r_done.high_y <= n_high_y;
            r_done.low_z  <= n_low_z;
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

>>> rtl/rbbc_center.sv
// ----------------------------------------------------------------------------
// rbbc_center
// midpoint of the extremes into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module rbbc_center
    import rbbc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_ext i_done,
    output logic      o_take,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_coord    o_center_x,
    output t_coord    o_center_y,
    output t_coord    o_bottom_z
);

    logic                        r_out_valid;
    t_coord                      r_cx, r_cy, r_bz;
    logic signed [COORD_BITS:0]  n_sum_x;
    logic signed [COORD_BITS:0]  n_sum_y;

    // half the sum always fits, no clamp needed
    always_comb begin
        n_sum_x = (COORD_BITS + 1)'(i_done.low_x) + (COORD_BITS + 1)'(i_done.high_x);
        n_sum_y = (COORD_BITS + 1)'(i_done.low_y) + (COORD_BITS + 1)'(i_done.high_y);
        o_take  = i_done.valid && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (o_take) begin
            r_cx <= n_sum_x[COORD_BITS:1];
            r_cy <= n_sum_y[COORD_BITS:1];
            r_bz <= i_done.low_z;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_center_x  = r_cx;
    assign o_center_y  = r_cy;
    assign o_bottom_z  = r_bz;

endmodule

`default_nettype wire

>>> rtl/rotated_bounding_box_bottom_center.sv
// ----------------------------------------------------------------------------
// rotated_bounding_box_bottom_center
// bottom-face center of a vertex cloud rotated in the xz plane
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ---------------------------------
//   in       sink       i_in_valid / o_in_ready   vertex x, y, z, last flag
//   out      source     o_out_valid / i_out_ready center x, center y, bottom z
//   cfg      sink       i_cfg_valid / o_cfg_ready register index, write data
//
// one vertex word per cycle unless the pipe is stalled; a result word is made
// from its last vertex through five registers (capture, products, round,
// extremes, midpoint)
// synchronous active-low reset clears valid bits, restores the trig and
// shift registers and returns the extremes to the +/-10000 mm sentinels
// the pipeline stalls only when a finished mesh waits behind a result word
// that the sink has not taken; config writes are always taken
//
`default_nettype none

module rotated_bounding_box_bottom_center
    import rbbc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // vertex stream
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire t_coord                  i_vertex_x,
    input  wire t_coord                  i_vertex_y,
    input  wire t_coord                  i_vertex_z,
    input  wire logic                    i_last_vertex,
    // result stream
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output t_coord                       o_center_x,
    output t_coord                       o_center_y,
    output t_coord                       o_bottom_z,
    // config writes
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data
);

    // config registers
    logic signed [TRIG_BITS-1:0] r_cos;
    logic signed [TRIG_BITS-1:0] r_sin;
    t_coord                      r_zshift;

    t_vtx r_vtx;
    t_rot w_rot;
    t_ext w_done;
    logic w_take;
    logic w_en;

    // a finished mesh that cannot move on holds the whole pipe
    assign w_en        = !(w_done.valid && !w_take);
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos    <= COS_RESET;
            r_sin    <= SIN_RESET;
            r_zshift <= ZSH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COS:    r_cos    <= i_cfg_data[TRIG_BITS-1:0];
                REG_SIN:    r_sin    <= i_cfg_data[TRIG_BITS-1:0];
                REG_ZSHIFT: r_zshift <= i_cfg_data[COORD_BITS-1:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // capture stage, z shift is added exactly (one bit wider)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx.valid <= 1'b0;
        end else if (w_en) begin
            r_vtx.valid <= i_in_valid;
        end
        if (w_en) begin
            r_vtx.last <= i_last_vertex;
            r_vtx.x    <= i_vertex_x;
            r_vtx.y    <= i_vertex_y;
            r_vtx.zs   <= ZS_BITS'(i_vertex_z) + ZS_BITS'(r_zshift);
        end
    end

    rbbc_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vtx   (r_vtx),
        .i_cos   (r_cos),
        .i_sin   (r_sin),
        .o_rot   (w_rot)
    );

    rbbc_extents u_extents (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_rot   (w_rot),
        .i_take  (w_take),
        .o_done  (w_done)
    );

    rbbc_center u_center (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_done      (w_done),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_center_x  (o_center_x),
        .o_center_y  (o_center_y),
        .o_bottom_z  (o_bottom_z)
    );

endmodule

`default_nettype wire
